// ===== src/sensor_frame_crc_check_and_convert_core_macros.svh =====
// Assertion macros shared by the sensor frame checker RTL.
`ifndef SENSOR_FRAME_CRC_CHECK_AND_CONVERT_CORE_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_AND_CONVERT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SFCC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sfcc invariant violated");
`define SFCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfcc implication violated");
`define SFCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcc next-cycle check violated");
`else
`define SFCC_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define SFCC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SFCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/sfcc_pkg.sv =====
// Types, constants and helper functions for the sensor frame checker.
package sfcc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Frame positions
  localparam logic [2:0] POS_HI0  = 3'd0;
  localparam logic [2:0] POS_LO0  = 3'd1;
  localparam logic [2:0] POS_CRC0 = 3'd2;
  localparam logic [2:0] POS_HI1  = 3'd3;
  localparam logic [2:0] POS_LO1  = 3'd4;
  localparam logic [2:0] POS_CRC1 = 3'd5;
  localparam logic [2:0] POS_LAST = POS_CRC1;

  localparam int PROD_W  = 31;
  localparam int CENTI_W = 15;

  localparam logic [PROD_W-1:0] TEMP_SPAN = 31'd17500;
  localparam logic [PROD_W-1:0] HUM_SPAN  = 31'd12500;
  localparam logic signed [CENTI_W:0] TEMP_OFFSET = -16'sd4500;
  localparam logic signed [CENTI_W:0] HUM_OFFSET  = -16'sd600;
  localparam logic [16:0] FULL_SCALE = 17'd65535;

  typedef struct packed {
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        first_ok;
    logic        second_ok;
  } frame_t;

  // Bytewise CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(p / 65535): q0 = p >> 16 leaves a remainder below twice the divisor.
  function automatic logic [CENTI_W-1:0] div_full_scale(input logic [PROD_W-1:0] p);
    logic [CENTI_W-1:0] q0;
    logic [16:0]        r;
    q0 = p[PROD_W-1:16];
    r  = {1'b0, p[15:0]} + {2'b00, q0};
    return (r >= FULL_SCALE) ? (q0 + 15'd1) : q0;
  endfunction

  function automatic logic [CENTI_W-1:0] to_centi(input logic [CENTI_W-1:0] q,
                                                 input logic signed [CENTI_W:0] offset);
    logic signed [CENTI_W:0] s;
    s = $signed({1'b0, q}) + offset;
    return s[CENTI_W-1:0];
  endfunction

endpackage

// ===== src/sfcc_scale.sv =====
// Two-stage conversion pipeline: scale multiply, then divide by full scale and offset.
`include "sensor_frame_crc_check_and_convert_core_macros.svh"
module sfcc_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_valid,
  output logic                          frame_ready,
  input  sfcc_pkg::frame_t              frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   first_word,
  output logic [15:0]                   second_word,
  output logic                          first_crc_ok,
  output logic                          second_crc_ok,
  output logic signed [sfcc_pkg::CENTI_W-1:0] temperature_centi,
  output logic signed [sfcc_pkg::CENTI_W-1:0] humidity_centi
);
  import sfcc_pkg::*;

  logic               s1_valid;
  frame_t             s1_frame;
  logic [PROD_W-1:0]  s1_temp_prod;
  logic [PROD_W-1:0]  s1_hum_prod;
  logic               s1_take;

  assign s1_take     = !out_valid || out_ready;
  assign frame_ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_ready) begin
      s1_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      s1_frame     <= frame;
      s1_temp_prod <= TEMP_SPAN * {15'd0, frame.first_word};
      s1_hum_prod  <= HUM_SPAN * {15'd0, frame.second_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_take) begin
      first_word        <= s1_frame.first_word;
      second_word       <= s1_frame.second_word;
      first_crc_ok      <= s1_frame.first_ok;
      second_crc_ok     <= s1_frame.second_ok;
      temperature_centi <= $signed(to_centi(div_full_scale(s1_temp_prod), TEMP_OFFSET));
      humidity_centi    <= $signed(to_centi(div_full_scale(s1_hum_prod), HUM_OFFSET));
    end
  end

  `SFCC_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_take, s1_valid && $stable(s1_temp_prod))
  `SFCC_ASSERT_NEXT(a_frame_loaded, clk, rst, frame_valid && frame_ready, s1_valid)
  `SFCC_ASSERT_IMP(a_out_from_s1, clk, rst, $rose(out_valid), $past(s1_valid))

endmodule

// ===== src/sensor_frame_crc_check_and_convert_core.sv =====
// Top level: sensor reply frame assembler with CRC-8 check and unit conversion.
//
// Input channel (in_valid/in_ready): one beat carries data_byte and frame_start.
// Six beats make a frame: word high, word low, CRC, word high, word low, CRC.
// frame_start forces the beat to byte 0 and drops any partial frame.
// Output channel (out_valid/out_ready): one beat per completed frame with both
// raw words, a CRC-ok flag per word, temperature and humidity in hundredths.
// Throughput: one input beat per cycle while in_ready is high. Bytes 0..4 only update frame state.
// Pipeline: accepting the sixth byte loads the scale multiply stage, then that
// stage loads the divide-by-full-scale and offset result into the output
// register, which raises out_valid.
// Stall: when out_ready is low the result holds in the output register and the
// multiply stage still takes one more frame; in_ready drops only when both
// stages are full.
// Reset (rst, synchronous): frame position returns to byte 0, the CRC to 0xFF,
// and both pipeline stages are emptied.
`include "sensor_frame_crc_check_and_convert_core_macros.svh"
module sensor_frame_crc_check_and_convert_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        first_word,
  output logic [15:0]        second_word,
  output logic               first_crc_ok,
  output logic               second_crc_ok,
  output logic signed [14:0] temperature_centi,
  output logic signed [14:0] humidity_centi
);
  import sfcc_pkg::*;

  logic [2:0]  byte_position;
  logic [7:0]  running_crc;
  logic [15:0] partial_word;
  logic [15:0] held_first_word;
  logic        held_first_ok;

  logic        restart;
  logic [2:0]  pos_eff;
  logic [7:0]  crc_eff;
  logic [7:0]  crc_next;
  logic        accept;
  logic        frame_valid;
  logic        frame_ready;
  frame_t      frame;

  assign restart  = frame_start || (byte_position > POS_LAST);
  assign pos_eff  = restart ? POS_HI0 : byte_position;
  assign crc_eff  = restart ? CRC_INIT : running_crc;
  assign crc_next = crc8_byte(crc_eff, data_byte);

  assign in_ready    = frame_ready;
  assign accept      = in_valid && in_ready;
  assign frame_valid = in_valid && (pos_eff == POS_CRC1);

  assign frame.first_word  = held_first_word;
  assign frame.second_word = partial_word;
  assign frame.first_ok    = held_first_ok;
  assign frame.second_ok   = (crc_eff == data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_HI0;
      running_crc     <= CRC_INIT;
      partial_word    <= 16'd0;
      held_first_word <= 16'd0;
      held_first_ok   <= 1'b0;
    end else if (accept) begin
      unique case (pos_eff)
        POS_HI0, POS_HI1: begin
          partial_word  <= {data_byte, 8'h00};
          running_crc   <= crc_next;
          byte_position <= pos_eff + 3'd1;
        end
        POS_LO0, POS_LO1: begin
          partial_word  <= partial_word | {8'h00, data_byte};
          running_crc   <= crc_next;
          byte_position <= pos_eff + 3'd1;
        end
        POS_CRC0: begin
          held_first_word <= partial_word;
          held_first_ok   <= (crc_eff == data_byte);
          running_crc     <= CRC_INIT;
          byte_position   <= POS_HI1;
        end
        POS_CRC1: begin
          running_crc   <= CRC_INIT;
          byte_position <= POS_HI0;
        end
        default: begin
          byte_position <= POS_HI0;
          running_crc   <= CRC_INIT;
        end
      endcase
    end
  end

  sfcc_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (frame_valid),
    .frame_ready       (frame_ready),
    .frame             (frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .first_word        (first_word),
    .second_word       (second_word),
    .first_crc_ok      (first_crc_ok),
    .second_crc_ok     (second_crc_ok),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi)
  );

  `SFCC_ASSERT_ALWAYS(a_pos_range, clk, rst, byte_position <= POS_LAST)
  `SFCC_ASSERT_NEXT(a_crc_restart, clk, rst, accept && (pos_eff == POS_CRC1), running_crc == CRC_INIT)
  `SFCC_ASSERT_IMP(a_ready_when_out_empty, clk, rst, !out_valid, in_ready)

endmodule
